// ----- hw/rtl/parity_filter_prefix_decoder_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the parity-filtered prefix-code decoder
// Two property templates used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PARITY_FILTER_PREFIX_DECODER_TOP_ASSERT_SVH
`define PARITY_FILTER_PREFIX_DECODER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PFPD_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PFPD_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/pfpd_pkg.sv -----
// ----------------------------------------------------------------------------
// pfpd_pkg
// Constants, codes and controller/datapath handshake types for the decoder.
// ----------------------------------------------------------------------------
package pfpd_pkg;

   localparam int NODE_COUNT    = 4096;
   localparam int NODE_W        = $clog2(NODE_COUNT);
   localparam int NODES_W       = NODE_W + 1;
   localparam int CODE_LEN_MAX  = 16;
   localparam int CODE_W        = 16;
   localparam int LEN_W         = 5;
   localparam int SYM_W         = 8;
   localparam int CNT_W         = 20;
   localparam int HEX_W         = 4;
   localparam int GROUP_BITS    = 9;
   localparam int DATA_BITS     = 8;
   localparam int FILL_W        = 4;
   localparam int STEP_W        = 4;
   localparam int RES_MAX       = 8;
   localparam int RES_IDX_W     = 3;
   localparam int RES_CNT_W     = 4;

   localparam logic [CNT_W-1:0] MAX_SYM_RESET = '1;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_HEX   = 2'd2
   } op_type;

   typedef struct packed {
      logic clear;
      logic rd_load;
      logic load_start;
      logic l_step;
      logic l_new;
      logic l_link;
      logic l_sym;
      logic hex_take;
      logic walk_eval;
      logic drain_push;
   } cmd_type;

   typedef struct packed {
      logic len_ok;
      logic found;
      logic full;
      logic lleft_one;
      logic grp_walk;
      logic walk_end;
      logic has_res;
      logic out_free;
      logic drain_last;
   } status_type;

endpackage

// ----- hw/rtl/pfpd_channels.sv -----
// ----------------------------------------------------------------------------
// pfpd channels
// Valid/ready channel interfaces: request, response and register write.
// ----------------------------------------------------------------------------
interface pfpd_req_if;
   import pfpd_pkg::*;
   logic                valid;
   logic                ready;
   op_type              op;
   logic [CODE_W-1:0]   code_bits;
   logic [LEN_W-1:0]    code_len;
   logic [SYM_W-1:0]    code_symbol;
   logic [HEX_W-1:0]    hex_digit;
   modport source (output valid, op, code_bits, code_len, code_symbol, hex_digit,
                   input ready);
   modport sink (input valid, op, code_bits, code_len, code_symbol, hex_digit,
                 output ready);
endinterface

interface pfpd_rsp_if;
   import pfpd_pkg::*;
   logic               valid;
   logic               ready;
   logic [SYM_W-1:0]   decoded_symbol;
   logic               last;
   logic               limit_reached;
   modport source (output valid, decoded_symbol, last, limit_reached, input ready);
   modport sink (input valid, decoded_symbol, last, limit_reached, output ready);
endinterface

interface pfpd_csr_if;
   import pfpd_pkg::*;
   logic               valid;
   logic               ready;
   logic [CNT_W-1:0]   data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ----- hw/rtl/pfpd_ctrl.sv -----
// ----------------------------------------------------------------------------
// pfpd_ctrl
// Sequencer for clear, code load, group walk and result drain.
// ----------------------------------------------------------------------------
module pfpd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  pfpd_pkg::op_type     req_op,
   output logic                 req_ready,
   input  pfpd_pkg::status_type status,
   output pfpd_pkg::cmd_type    cmd
);
   import pfpd_pkg::*;

   typedef enum logic [7:0] {
      S_INIT  = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_LSTEP = 8'b0000_0100,
      S_LNEW  = 8'b0000_1000,
      S_LLINK = 8'b0001_0000,
      S_LSYM  = 8'b0010_0000,
      S_WALK  = 8'b0100_0000,
      S_DRAIN = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      unique case (state_ff)
         S_INIT: begin
            // set up the root node after reset
            cmd.clear = 1'b1;
            state_in  = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_op)
                  OP_CLEAR: cmd.clear = 1'b1;
                  OP_LOAD: begin
                     cmd.rd_load = 1'b1;
                     if (status.len_ok) begin
                        cmd.load_start = 1'b1;
                        state_in       = S_LSTEP;
                     end
                  end
                  OP_HEX: begin
                     cmd.hex_take = 1'b1;
                     if (status.grp_walk) begin
                        state_in = S_WALK;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_LSTEP: begin
            cmd.rd_load = 1'b1;
            if (status.found) begin
               cmd.l_step = 1'b1;
               state_in   = status.lleft_one ? S_LSYM : S_LSTEP;
            end else if (status.full) begin
               // trie full: drop the rest of this code
               state_in = S_IDLE;
            end else begin
               state_in = S_LNEW;
            end
         end
         S_LNEW: begin
            cmd.rd_load = 1'b1;
            cmd.l_new   = 1'b1;
            state_in    = S_LLINK;
         end
         S_LLINK: begin
            cmd.rd_load = 1'b1;
            cmd.l_link  = 1'b1;
            state_in    = status.lleft_one ? S_LSYM : S_LSTEP;
         end
         S_LSYM: begin
            cmd.l_sym = 1'b1;
            state_in  = S_IDLE;
         end
         S_WALK: begin
            cmd.walk_eval = 1'b1;
            if (status.walk_end) begin
               state_in = status.has_res ? S_DRAIN : S_IDLE;
            end
         end
         S_DRAIN: begin
            if (status.out_free) begin
               cmd.drain_push = 1'b1;
               if (status.drain_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/pfpd_datapath.sv -----
// ----------------------------------------------------------------------------
// pfpd_datapath
// Trie memories, group assembly, walk and load cursors, result buffer.
// ----------------------------------------------------------------------------
module pfpd_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  pfpd_pkg::cmd_type             cmd,
   output pfpd_pkg::status_type          status,
   input  logic [pfpd_pkg::CODE_W-1:0]   req_code_bits,
   input  logic [pfpd_pkg::LEN_W-1:0]    req_code_len,
   input  logic [pfpd_pkg::SYM_W-1:0]    req_code_symbol,
   input  logic [pfpd_pkg::HEX_W-1:0]    req_hex_digit,
   input  logic                          csr_valid,
   input  logic [pfpd_pkg::CNT_W-1:0]    csr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pfpd_pkg::SYM_W-1:0]    rsp_decoded_symbol,
   output logic                          rsp_last,
   output logic                          rsp_limit_reached
);
   import pfpd_pkg::*;

   // trie storage
   logic [NODE_W-1:0] child0_mem [NODE_COUNT];
   logic [NODE_W-1:0] child1_mem [NODE_COUNT];
   logic [SYM_W-1:0]  sym_mem    [NODE_COUNT];
   logic [NODE_W-1:0] c0_rd_ff, c1_rd_ff;
   logic [SYM_W-1:0]  s_rd_ff;
   logic              c0_we, c1_we, s_we;
   logic [NODE_W-1:0] c0_wa, c1_wa, s_wa, c0_wd, c1_wd, rd_addr;
   logic [SYM_W-1:0]  s_wd;

   // control state
   logic [CNT_W-1:0]     max_ff, max_in, count_ff, count_in, count_inc;
   logic [NODES_W-1:0]   nodes_ff, nodes_in;
   logic [GROUP_BITS-1:0] gbits_ff, gbits_in;
   logic [FILL_W-1:0]    gfill_ff, gfill_in;
   logic [NODE_W-1:0]    walk_ff, walk_in, lcur_ff, lcur_in;
   logic                 arr_ff, arr_in;
   logic [STEP_W-1:0]    wleft_ff, wleft_in;
   logic [LEN_W-1:0]     lleft_ff, lleft_in;
   logic [RES_CNT_W-1:0] nres_ff, nres_in;
   logic [RES_IDX_W-1:0] ridx_ff, ridx_in;
   logic                 rvalid_ff, rvalid_in;

   // payload
   logic [DATA_BITS-1:0] wbits_ff, wbits_in;
   logic [CODE_W-1:0]    lcode_ff, lcode_in;
   logic [SYM_W-1:0]     lsym_ff, lsym_in;
   logic [SYM_W-1:0]     buf_sym_ff [RES_MAX];
   logic                 buf_lim_ff [RES_MAX];
   logic [SYM_W-1:0]     rsym_ff;
   logic                 rlast_ff, rlim_ff;

   // combinational helpers
   logic                  lbit, wbit, emit, grp_done, last_res;
   logic [NODE_W-1:0]     lnxt, wnxt;
   logic [GROUP_BITS-1:0] gb, grp;
   logic [FILL_W-1:0]     gf;
   logic [LEN_W-1:0]      lshift;

   assign lbit      = lcode_ff[CODE_W-1];
   assign lnxt      = lbit ? c1_rd_ff : c0_rd_ff;
   assign wbit      = wbits_ff[DATA_BITS-1];
   assign wnxt      = wbit ? c1_rd_ff : c0_rd_ff;
   assign emit      = arr_ff && (s_rd_ff != '0);
   assign count_inc = count_ff + CNT_W'(1);
   assign lshift    = LEN_W'(CODE_W) - req_code_len;
   assign last_res  = (RES_CNT_W'(ridx_ff) + RES_CNT_W'(1)) == nres_ff;

   // shift the hex digit into the 9-bit group, at most one group completes
   always_comb begin
      gb       = gbits_ff;
      gf       = gfill_ff;
      grp      = '0;
      grp_done = 1'b0;
      for (int i = HEX_W - 1; i >= 0; i--) begin
         gb = {gb[GROUP_BITS-2:0], req_hex_digit[i]};
         gf = gf + FILL_W'(1);
         if (gf >= FILL_W'(GROUP_BITS)) begin
            grp      = gb;
            grp_done = 1'b1;
            gb       = '0;
            gf       = '0;
         end
      end
   end

   always_comb begin
      status.len_ok     = (req_code_len != '0) && (req_code_len <= LEN_W'(CODE_LEN_MAX));
      status.found      = (lnxt != '0);
      status.full       = (nodes_ff >= NODES_W'(NODE_COUNT));
      status.lleft_one  = (lleft_ff == LEN_W'(1));
      status.grp_walk   = grp_done && (^grp) && (count_ff < max_ff);
      status.walk_end   = emit ? (wleft_ff == '0)
                               : ((wleft_ff == '0) || (count_ff >= max_ff));
      status.has_res    = (nres_ff != '0) || emit;
      status.out_free   = !rvalid_ff || rsp_ready;
      status.drain_last = last_res;
   end

   // memory write port selection
   always_comb begin
      c0_we = 1'b0;
      c1_we = 1'b0;
      s_we  = 1'b0;
      c0_wa = lcur_ff;
      c1_wa = lcur_ff;
      s_wa  = lcur_ff;
      c0_wd = '0;
      c1_wd = '0;
      s_wd  = lsym_ff;
      priority if (cmd.clear) begin
         c0_we = 1'b1;
         c1_we = 1'b1;
         s_we  = 1'b1;
         c0_wa = '0;
         c1_wa = '0;
         s_wa  = '0;
         s_wd  = '0;
      end else if (cmd.l_new) begin
         c0_we = 1'b1;
         c1_we = 1'b1;
         s_we  = 1'b1;
         c0_wa = nodes_ff[NODE_W-1:0];
         c1_wa = nodes_ff[NODE_W-1:0];
         s_wa  = nodes_ff[NODE_W-1:0];
         s_wd  = '0;
      end else if (cmd.l_link) begin
         c0_we = !lbit;
         c1_we = lbit;
         c0_wd = nodes_ff[NODE_W-1:0];
         c1_wd = nodes_ff[NODE_W-1:0];
      end else if (cmd.l_sym) begin
         s_we = 1'b1;
      end else begin
      end
   end

   assign rd_addr = cmd.rd_load ? lcur_in : walk_in;

   always_ff @(posedge clock) begin
      if (c0_we) begin
         child0_mem[c0_wa] <= c0_wd;
      end
      c0_rd_ff <= child0_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (c1_we) begin
         child1_mem[c1_wa] <= c1_wd;
      end
      c1_rd_ff <= child1_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         sym_mem[s_wa] <= s_wd;
      end
      s_rd_ff <= sym_mem[rd_addr];
   end

   // next-state logic
   always_comb begin
      max_in    = csr_valid ? csr_data : max_ff;
      count_in  = count_ff;
      nodes_in  = nodes_ff;
      gbits_in  = gbits_ff;
      gfill_in  = gfill_ff;
      walk_in   = walk_ff;
      arr_in    = arr_ff;
      wleft_in  = wleft_ff;
      wbits_in  = wbits_ff;
      lcur_in   = lcur_ff;
      lcode_in  = lcode_ff;
      lleft_in  = lleft_ff;
      lsym_in   = lsym_ff;
      nres_in   = nres_ff;
      ridx_in   = ridx_ff;
      rvalid_in = rvalid_ff && !rsp_ready;

      if (cmd.clear) begin
         nodes_in = NODES_W'(1);
         gbits_in = '0;
         gfill_in = '0;
         walk_in  = '0;
         count_in = '0;
      end

      if (cmd.load_start) begin
         lcur_in  = '0;
         lcode_in = req_code_bits << lshift;
         lleft_in = req_code_len;
         lsym_in  = req_code_symbol;
      end

      if (cmd.l_step) begin
         lcur_in  = lnxt;
         lcode_in = lcode_ff << 1;
         lleft_in = lleft_ff - LEN_W'(1);
      end

      if (cmd.l_link) begin
         lcur_in  = nodes_ff[NODE_W-1:0];
         nodes_in = nodes_ff + NODES_W'(1);
         lcode_in = lcode_ff << 1;
         lleft_in = lleft_ff - LEN_W'(1);
      end

      if (cmd.hex_take) begin
         gbits_in = gb;
         gfill_in = gf;
         if (status.grp_walk) begin
            wbits_in = grp[GROUP_BITS-1:1];
            wleft_in = STEP_W'(DATA_BITS);
            arr_in   = 1'b0;
            nres_in  = '0;
            ridx_in  = '0;
         end
      end

      if (cmd.walk_eval) begin
         if (emit) begin
            // symbol found: record it and restart from the root
            nres_in  = nres_ff + RES_CNT_W'(1);
            count_in = count_inc;
            walk_in  = '0;
            arr_in   = 1'b0;
         end else if ((wleft_ff != '0) && (count_ff < max_ff)) begin
            // missing child drops back to the root
            walk_in  = wnxt;
            arr_in   = (wnxt != '0);
            wbits_in = wbits_ff << 1;
            wleft_in = wleft_ff - STEP_W'(1);
         end
      end

      if (cmd.drain_push) begin
         rvalid_in = 1'b1;
         ridx_in   = ridx_ff + RES_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff    <= MAX_SYM_RESET;
         count_ff  <= '0;
         nodes_ff  <= NODES_W'(1);
         gbits_ff  <= '0;
         gfill_ff  <= '0;
         walk_ff   <= '0;
         arr_ff    <= 1'b0;
         wleft_ff  <= '0;
         lcur_ff   <= '0;
         lleft_ff  <= '0;
         nres_ff   <= '0;
         ridx_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         max_ff    <= max_in;
         count_ff  <= count_in;
         nodes_ff  <= nodes_in;
         gbits_ff  <= gbits_in;
         gfill_ff  <= gfill_in;
         walk_ff   <= walk_in;
         arr_ff    <= arr_in;
         wleft_ff  <= wleft_in;
         lcur_ff   <= lcur_in;
         lleft_ff  <= lleft_in;
         nres_ff   <= nres_in;
         ridx_ff   <= ridx_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      wbits_ff <= wbits_in;
      lcode_ff <= lcode_in;
      lsym_ff  <= lsym_in;
      if (cmd.walk_eval && emit) begin
         buf_sym_ff[nres_ff[RES_IDX_W-1:0]] <= s_rd_ff;
         buf_lim_ff[nres_ff[RES_IDX_W-1:0]] <= (count_inc == max_ff);
      end
      if (cmd.drain_push) begin
         rsym_ff  <= buf_sym_ff[ridx_ff];
         rlim_ff  <= buf_lim_ff[ridx_ff];
         rlast_ff <= last_res;
      end
   end

   assign rsp_valid          = rvalid_ff;
   assign rsp_decoded_symbol = rsym_ff;
   assign rsp_last           = rlast_ff;
   assign rsp_limit_reached  = rlim_ff;

endmodule

// ----- hw/rtl/parity_filter_prefix_decoder_top.sv -----
// ----------------------------------------------------------------------------
// parity_filter_prefix_decoder_top
// Prefix-code trie decoder fed by parity-checked 9-bit groups of hex digits.
//
//   channel  dir  transfer when        carries
//   req_if   in   valid && ready       op, code fields, hex digit
//   rsp_if   out  valid && ready       decoded symbol, last, limit flag
//   csr_if   in   valid && ready       max_symbols (always ready)
//
// Clear and hex digits that complete no walked group finish in the idle state.
// A load follows its code bit by bit from the root through an existing child or
// a new node (allocate, then link) and writes the symbol; the trie memories have
// a single read port. A walked group steps the trie once per data bit, records
// each symbol and restarts at the root, until eight bits are used or the symbol
// limit is hit; symbols then drain one per cycle. After reset, S_INIT sets up
// the root node. A stalled response holds the drain; requests wait until idle.
// ----------------------------------------------------------------------------
`include "parity_filter_prefix_decoder_top_assert.svh"

module parity_filter_prefix_decoder_top (
   input  logic       clock,
   input  logic       reset,
   pfpd_req_if.sink   req_if,
   pfpd_rsp_if.source rsp_if,
   pfpd_csr_if.sink   csr_if
);
   import pfpd_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       clear_xfer;

   assign csr_if.ready = 1'b1;
   assign clear_xfer   = req_if.valid && req_if.ready && (req_if.op == OP_CLEAR);

   pfpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_op    (req_if.op),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pfpd_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_code_bits      (req_if.code_bits),
      .req_code_len       (req_if.code_len),
      .req_code_symbol    (req_if.code_symbol),
      .req_hex_digit      (req_if.hex_digit),
      .csr_valid          (csr_if.valid),
      .csr_data           (csr_if.data),
      .rsp_valid          (rsp_if.valid),
      .rsp_ready          (rsp_if.ready),
      .rsp_decoded_symbol (rsp_if.decoded_symbol),
      .rsp_last           (rsp_if.last),
      .rsp_limit_reached  (rsp_if.limit_reached)
   );

   `PFPD_HOLDS(a_rsp_sym_nonzero, clock, reset, rsp_if.valid, rsp_if.decoded_symbol != '0, "zero symbol")
   `PFPD_NEXT(a_clear_single, clock, reset, clear_xfer, req_if.ready, "clear did not return to idle")
   `PFPD_HOLDS(a_push_free, clock, reset, cmd.drain_push, status.out_free, "push into full output")

endmodule
